// ===== rtl/ffha_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the first-fit heap allocator.
// No dependencies; every other file refers to it by scoped names.
package ffha_pkg;

  localparam int unsigned FIELD_W  = 15;
  localparam int unsigned STATUS_W = 3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_REUSED   = 3'd0,
    ST_MERGED   = 3'd1,
    ST_APPENDED = 3'd2,
    ST_FREED    = 3'd3,
    ST_REJECTED = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  typedef struct packed {
    logic               free;
    logic [FIELD_W-1:0] size;
    logic [FIELD_W-1:0] offset;
  } entry_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic    load;        // capture a new request, restart the scan
    logic    rd_scan;     // read the table at the scan index
    logic    rd_move;     // read the table at the compaction index
    logic    step_used;   // used entry: drop the run, advance
    logic    step_free;   // free entry without a fit: grow the run, advance
    logic    step_plain;  // free-request scan: advance only
    logic    grant;       // reuse the entry at the scan index
    logic    merge;       // fold the run into its first entry
    logic    move;        // shift one entry down during compaction
    logic    finish;      // shrink the block count after compaction
    logic    append;      // add a block at the top of the heap
    logic    mark_free;   // mark the entry at the scan index free
    logic    res_we;      // load the result register
    status_t res_status;
  } cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic is_free_op;
    logic zero_req;
    logic scan_done;
    logic rd_free;
    logic hit;
    logic single;
    logic match;
    logic full;
    logic move_done;
  } stat_t;

endpackage

// ===== rtl/ffha_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and results.
// Depends on ffha_pkg for field widths.
interface ffha_req_if;
  logic                           valid;
  logic                           ready;
  logic                           opcode;
  logic [ffha_pkg::FIELD_W-1:0]   request_size;
  logic [ffha_pkg::FIELD_W-1:0]   release_address;
  modport source (output valid, opcode, request_size, release_address, input ready);
  modport sink   (input valid, opcode, request_size, release_address, output ready);
endinterface

interface ffha_res_if;
  logic                           valid;
  logic                           ready;
  logic [ffha_pkg::FIELD_W-1:0]   payload_address;
  logic [ffha_pkg::STATUS_W-1:0]  status;
  modport source (output valid, payload_address, status, input ready);
  modport sink   (input valid, payload_address, status, output ready);
endinterface

// ===== rtl/ffha_dp.sv =====
`timescale 1ns / 1ps
// Datapath: block table memory, scan and compaction counters, result register.
// Depends on ffha_pkg; driven by the ffha_ctrl sequencer.
module ffha_dp #(
  parameter int unsigned HEAP_BYTES   = 16384,
  parameter int unsigned HEADER_BYTES = 16,
  parameter int unsigned MAX_BLOCKS   = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ffha_pkg::cmd_t                cmd,
  output ffha_pkg::stat_t               stat,
  input  logic                          req_opcode,
  input  logic [ffha_pkg::FIELD_W-1:0]  req_size,
  input  logic [ffha_pkg::FIELD_W-1:0]  req_address,
  output logic [ffha_pkg::FIELD_W-1:0]  res_address,
  output ffha_pkg::status_t             res_status
);

  localparam int unsigned FW    = ffha_pkg::FIELD_W;
  localparam int unsigned AW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CW    = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned SUM_W = FW + CW;
  localparam int unsigned TOP_W = FW + 2;

  localparam logic [FW-1:0]    HDR     = FW'(HEADER_BYTES);
  localparam logic [FW:0]      HDR_X   = (FW + 1)'(HEADER_BYTES);
  localparam logic [TOP_W-1:0] HDR_T   = TOP_W'(HEADER_BYTES);
  localparam logic [TOP_W-1:0] HEAP_T  = TOP_W'(HEAP_BYTES);
  localparam logic [CW-1:0]    MAX_CNT = CW'(MAX_BLOCKS);

  ffha_pkg::entry_t mem [MAX_BLOCKS];
  ffha_pkg::entry_t rd_q_r;
  ffha_pkg::entry_t wr_data;
  logic [AW-1:0]    wr_addr;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;

  logic [CW-1:0]    block_count_r, block_count_nxt;
  logic [FW-1:0]    heap_top_r, heap_top_nxt;
  logic [CW-1:0]    idx_r, start_r, k_r, removed_r;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [FW-1:0]    start_off_r;
  logic             op_r;
  logic [FW-1:0]    size_r, addr_r;
  logic [FW-1:0]    merged_size;
  logic [TOP_W-1:0] top_end;
  logic [CW-1:0]    move_dst;

  assign sum_nxt     = sum_r + SUM_W'(rd_q_r.size);
  assign merged_size = rd_q_r.offset - start_off_r + rd_q_r.size;
  assign top_end     = TOP_W'(heap_top_r) + HDR_T + TOP_W'(size_r);
  assign move_dst    = k_r - removed_r;
  assign rd_addr     = cmd.rd_move ? k_r[AW-1:0] : idx_r[AW-1:0];

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = idx_r[AW-1:0];
    wr_data = rd_q_r;
    if (cmd.grant) begin
      wr_data.free = 1'b0;
    end else if (cmd.mark_free) begin
      wr_data.free = 1'b1;
    end else if (cmd.merge) begin
      wr_addr = start_r[AW-1:0];
      wr_data = '{free: 1'b0, size: merged_size, offset: start_off_r};
    end else if (cmd.move) begin
      wr_addr = move_dst[AW-1:0];
    end else if (cmd.append) begin
      wr_addr = block_count_r[AW-1:0];
      wr_data = '{free: 1'b0, size: size_r, offset: heap_top_r};
    end else begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_scan || cmd.rd_move) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_comb begin
    block_count_nxt = block_count_r;
    heap_top_nxt    = heap_top_r;
    if (cmd.finish) begin
      block_count_nxt = block_count_r - removed_r;
    end else if (cmd.append) begin
      block_count_nxt = block_count_r + CW'(1);
      heap_top_nxt    = top_end[FW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_count_r <= '0;
      heap_top_r    <= '0;
    end else begin
      block_count_r <= block_count_nxt;
      heap_top_r    <= heap_top_nxt;
    end
  end

  // Scan and compaction bookkeeping.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= req_opcode;
      size_r  <= req_size;
      addr_r  <= req_address;
      idx_r   <= '0;
      start_r <= '0;
      sum_r   <= '0;
    end
    if (cmd.step_used) begin
      idx_r   <= idx_r + CW'(1);
      start_r <= idx_r + CW'(1);
      sum_r   <= '0;
    end
    if (cmd.step_free) begin
      idx_r <= idx_r + CW'(1);
      sum_r <= sum_nxt;
      if (start_r == idx_r) begin
        start_off_r <= rd_q_r.offset;
      end
    end
    if (cmd.step_plain) begin
      idx_r <= idx_r + CW'(1);
    end
    if (cmd.merge) begin
      k_r       <= idx_r + CW'(1);
      removed_r <= idx_r - start_r;
    end
    if (cmd.move) begin
      k_r <= k_r + CW'(1);
    end
  end

  // Result register: the address follows from the outcome.
  always_ff @(posedge clk) begin
    if (cmd.res_we) begin
      res_status <= cmd.res_status;
      case (cmd.res_status)
        ffha_pkg::ST_REUSED:   res_address <= rd_q_r.offset + HDR;
        ffha_pkg::ST_MERGED:   res_address <= start_off_r + HDR;
        ffha_pkg::ST_APPENDED: res_address <= heap_top_r + HDR;
        default:               res_address <= '0;
      endcase
    end
  end

  assign stat.is_free_op = (op_r == ffha_pkg::OP_FREE);
  assign stat.zero_req   = (op_r == ffha_pkg::OP_FREE) ? (addr_r == '0) : (size_r == '0);
  assign stat.scan_done  = (idx_r >= block_count_r);
  assign stat.rd_free    = rd_q_r.free;
  assign stat.hit        = (sum_nxt > SUM_W'(size_r));
  assign stat.single     = (start_r == idx_r);
  assign stat.match      = (({1'b0, rd_q_r.offset} + HDR_X) == {1'b0, addr_r});
  assign stat.full       = (block_count_r == MAX_CNT) || (top_end > HEAP_T);
  assign stat.move_done  = (k_r >= block_count_r);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    block_count_r <= MAX_CNT)
    else $error("block count beyond table depth");

  a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
    TOP_W'(heap_top_r) <= HEAP_T)
    else $error("heap top beyond heap size");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.append |=> block_count_r == $past(block_count_r) + CW'(1))
    else $error("append did not grow the table");

endmodule

// ===== rtl/ffha_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the allocator: scan, grant, merge-and-compact, append, free.
// Depends on ffha_pkg; commands the ffha_dp datapath.
module ffha_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  ffha_pkg::stat_t stat,
  output ffha_pkg::cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SCAN_RD = 6'b000010,
    S_SCAN_EV = 6'b000100,
    S_MOVE_RD = 6'b001000,
    S_MOVE_EV = 6'b010000,
    S_RESP    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_RESP);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (stat.zero_req) begin
          cmd.res_we     = 1'b1;
          cmd.res_status = ffha_pkg::ST_REJECTED;
          state_nxt      = S_RESP;
        end else if (stat.scan_done) begin
          cmd.res_we = 1'b1;
          state_nxt  = S_RESP;
          if (stat.is_free_op || stat.full) begin
            cmd.res_status = ffha_pkg::ST_FULL;
          end else begin
            cmd.append     = 1'b1;
            cmd.res_status = ffha_pkg::ST_APPENDED;
          end
        end else begin
          cmd.rd_scan = 1'b1;
          state_nxt   = S_SCAN_EV;
        end
      end
      S_SCAN_EV: begin
        state_nxt = S_SCAN_RD;
        if (stat.is_free_op) begin
          if (stat.match) begin
            cmd.mark_free  = 1'b1;
            cmd.res_we     = 1'b1;
            cmd.res_status = ffha_pkg::ST_FREED;
            state_nxt      = S_RESP;
          end else begin
            cmd.step_plain = 1'b1;
          end
        end else if (!stat.rd_free) begin
          cmd.step_used = 1'b1;
        end else if (!stat.hit) begin
          cmd.step_free = 1'b1;
        end else if (stat.single) begin
          cmd.grant      = 1'b1;
          cmd.res_we     = 1'b1;
          cmd.res_status = ffha_pkg::ST_REUSED;
          state_nxt      = S_RESP;
        end else begin
          cmd.merge      = 1'b1;
          cmd.res_we     = 1'b1;
          cmd.res_status = ffha_pkg::ST_MERGED;
          state_nxt      = S_MOVE_RD;
        end
      end
      S_MOVE_RD: begin
        if (stat.move_done) begin
          cmd.finish = 1'b1;
          state_nxt  = S_RESP;
        end else begin
          cmd.rd_move = 1'b1;
          state_nxt   = S_MOVE_EV;
        end
      end
      S_MOVE_EV: begin
        cmd.move  = 1'b1;
        state_nxt = S_MOVE_RD;
      end
      S_RESP: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/first_fit_heap_allocator_unit.sv =====
`timescale 1ns / 1ps
// First-fit heap allocator with coalescing of adjacent free blocks.
// Use: present a request beat on in_bus (opcode 0 allocate request_size
// bytes, opcode 1 free release_address). One result beat follows on
// out_bus carrying payload_address and status (reused, merged, appended,
// freed, rejected/null, full/unknown).
// Timing: one request at a time. Each table entry visited takes a registered
// memory read, then an evaluate step; a merge then shifts each later entry
// down during compaction (read, then write) before the block count shrinks.
// A reject resolves without scanning the table.
// Reset (synchronous, active low) empties the table and sets the heap top
// to zero; no clearing pass is needed, as only entries below the block
// count are ever read.
// A stalled receiver holds the result beat; no new request is taken until
// it has been delivered.
module first_fit_heap_allocator_unit #(
  parameter int unsigned HEAP_BYTES   = 16384,
  parameter int unsigned HEADER_BYTES = 16,
  parameter int unsigned MAX_BLOCKS   = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  ffha_req_if.sink    in_bus,
  ffha_res_if.source  out_bus
);

  ffha_pkg::cmd_t    cmd;
  ffha_pkg::stat_t   stat;
  ffha_pkg::status_t res_status;

  // Sequencer: owns the handshakes and steps the datapath.
  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: block table, counters and the held result beat.
  ffha_dp #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_BLOCKS   (MAX_BLOCKS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .req_opcode  (in_bus.opcode),
    .req_size    (in_bus.request_size),
    .req_address (in_bus.release_address),
    .res_address (out_bus.payload_address),
    .res_status  (res_status)
  );

  assign out_bus.status = res_status;

  // Never take a request while a result beat is outstanding.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_bus.ready |-> !out_bus.valid)
    else $error("request taken with result pending");

  // Busy straight after accepting a request.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_bus.valid && in_bus.ready) |=> !in_bus.ready)
    else $error("ready stayed high after accept");

  // Ready again once the result beat has gone.
  a_ready_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.ready) |=> in_bus.ready)
    else $error("not ready after result delivered");

endmodule

// ===== tb/first_fit_heap_allocator_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the first-fit heap allocator: directed and random
// allocate/free beats, checked against an in-bench model of the block table.
// Depends on ffha_pkg, ffha_if and the allocator unit.
module first_fit_heap_allocator_unit_tb;

  localparam int unsigned HEAP_BYTES   = 16384;
  localparam int unsigned HEADER_BYTES = 16;
  localparam int unsigned MAX_BLOCKS   = 64;
  localparam int unsigned STALL_LIMIT  = 20000;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned FW           = ffha_pkg::FIELD_W;

  typedef struct packed {
    logic          opcode;
    logic [FW-1:0] request_size;
    logic [FW-1:0] release_address;
  } request_t;

  typedef struct packed {
    logic [FW-1:0]     payload_address;
    ffha_pkg::status_t status;
  } grant_t;

  logic clk;
  logic rst_n;

  ffha_req_if in_bus ();
  ffha_res_if out_bus ();

  first_fit_heap_allocator_unit #(
    .HEAP_BYTES  (HEAP_BYTES),
    .HEADER_BYTES(HEADER_BYTES),
    .MAX_BLOCKS  (MAX_BLOCKS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus.sink),
    .out_bus(out_bus.source)
  );

  // Shadow copy of the block table, updated as each request beat is taken.
  int unsigned blk_offset [MAX_BLOCKS];
  int unsigned blk_size   [MAX_BLOCKS];
  bit          blk_free   [MAX_BLOCKS];
  int unsigned blk_count;
  int unsigned top_ptr;

  request_t pending_reqs [$];
  grant_t   expected_grants [$];
  int unsigned error_count;
  int unsigned idle_cycles;
  int unsigned hold_requests;  // long receiver hold-offs asked for by stimulus
  int unsigned hold_served;
  int unsigned hold_left;
  int unsigned sent_count;
  int unsigned accept_count;
  bit          pause_sender;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Compute the allocator's answer and advance the shadow table.
  function automatic grant_t allocate_or_free(request_t r);
    grant_t      g;
    int unsigned start, sum, removed, n, a;
    g.payload_address = '0;
    g.status = ffha_pkg::ST_REJECTED;
    if (r.opcode == ffha_pkg::OP_FREE) begin
      a = r.release_address;
      if (a == 0) return g;
      g.status = ffha_pkg::ST_FULL;
      for (int i = 0; i < blk_count; i++) begin
        if (blk_offset[i] + HEADER_BYTES == a) begin
          blk_free[i] = 1'b1;
          g.status = ffha_pkg::ST_FREED;
          return g;
        end
      end
      return g;
    end
    n = r.request_size;
    if (n == 0) return g;
    start = 0;
    sum = 0;
    for (int i = 0; i < blk_count; i++) begin
      if (!blk_free[i]) begin
        sum = 0;
        start = i + 1;
        continue;
      end
      sum += blk_size[i];
      if (sum > n) begin
        if (start == i) begin
          blk_free[i] = 1'b0;
          g.status = ffha_pkg::ST_REUSED;
        end else begin
          removed = i - start;
          blk_size[start] = (blk_offset[i] - blk_offset[start] + blk_size[i]) & 16'h7FFF;
          blk_free[start] = 1'b0;
          for (int k = i + 1; k < blk_count; k++) begin
            blk_offset[k - removed] = blk_offset[k];
            blk_size[k - removed]   = blk_size[k];
            blk_free[k - removed]   = blk_free[k];
          end
          blk_count -= removed;
          g.status = ffha_pkg::ST_MERGED;
        end
        g.payload_address = FW'(blk_offset[start] + HEADER_BYTES);
        return g;
      end
    end
    g.status = ffha_pkg::ST_FULL;
    if (blk_count >= MAX_BLOCKS) return g;
    if (top_ptr + HEADER_BYTES + n > HEAP_BYTES) return g;
    blk_offset[blk_count] = top_ptr;
    blk_size[blk_count]   = n;
    blk_free[blk_count]   = 1'b0;
    g.payload_address = FW'(top_ptr + HEADER_BYTES);
    g.status = ffha_pkg::ST_APPENDED;
    blk_count++;
    top_ptr = (top_ptr + HEADER_BYTES + n) & 16'h7FFF;
    return g;
  endfunction

  // Gap length: mostly zero or short, now and then long.
  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Driver: offer queued beats at the falling edge, honouring random gaps.
  // A beat stays on the bus until the monitor has seen it taken.
  int unsigned send_gap;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      send_gap = 0;
    end else if (in_bus.valid && sent_count != accept_count) begin
      // hold the beat until it is taken
    end else if (send_gap != 0 || pause_sender || pending_reqs.size() == 0) begin
      in_bus.valid <= 1'b0;
      if (send_gap != 0) send_gap--;
    end else begin
      request_t r;
      r = pending_reqs.pop_front();
      in_bus.valid           <= 1'b1;
      in_bus.opcode          <= r.opcode;
      in_bus.request_size    <= r.request_size;
      in_bus.release_address <= r.release_address;
      sent_count++;
      send_gap = gap_len();
    end
  end

  // Receiver ready: random stalls, plus a long hold-off counted here.
  int unsigned recv_gap;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      recv_gap = 0;
    end else if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = LONG_HOLD;
      out_bus.ready <= 1'b0;
    end else if (hold_left != 0 || recv_gap != 0) begin
      out_bus.ready <= 1'b0;
      if (hold_left != 0) hold_left--;
      else recv_gap--;
    end else begin
      out_bus.ready <= 1'b1;
      if (out_bus.valid) recv_gap = gap_len();
    end
  end

  // Monitor: predict on each accepted request, check each accepted result.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (in_bus.valid && in_bus.ready) begin
        request_t r;
        r.opcode          = in_bus.opcode;
        r.request_size    = in_bus.request_size;
        r.release_address = in_bus.release_address;
        expected_grants.push_back(allocate_or_free(r));
        accept_count++;
      end
      if (out_bus.valid && out_bus.ready) begin
        if (expected_grants.size() == 0) begin
          $display("%0t: unexpected result beat addr=%0d status=%0d", $time,
                   out_bus.payload_address, out_bus.status);
          error_count++;
        end else begin
          grant_t g;
          g = expected_grants.pop_front();
          if (out_bus.payload_address !== g.payload_address) begin
            $display("%0t: payload_address expected %0d actual %0d", $time,
                     g.payload_address, out_bus.payload_address);
            error_count++;
          end
          if (out_bus.status !== g.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     g.status, out_bus.status);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst_n && idle_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic request_t mk_alloc(int unsigned n);
    request_t r;
    r.opcode = ffha_pkg::OP_ALLOC;
    r.request_size = FW'(n);
    r.release_address = FW'($urandom);
    return r;
  endfunction

  function automatic request_t mk_free(int unsigned a);
    request_t r;
    r.opcode = ffha_pkg::OP_FREE;
    r.request_size = FW'($urandom);
    r.release_address = FW'(a);
    return r;
  endfunction

  // Pick a payload address of a live block, or junk now and then.
  function automatic int unsigned pick_addr();
    if (blk_count == 0 || $urandom_range(19) == 0) return $urandom_range(16384);
    return blk_offset[$urandom_range(blk_count - 1)] + HEADER_BYTES;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_grants.size() != 0 || in_bus.valid)
      @(posedge clk);
  endtask

  // Stimulus: predictions use the shadow table, so fill in rounds and drain.
  initial begin
    int unsigned sz;
    error_count = 0;
    idle_cycles = 0;
    hold_requests = 0;
    hold_served = 0;
    hold_left = 0;
    sent_count = 0;
    accept_count = 0;
    pause_sender = 0;
    blk_count = 0;
    top_ptr = 0;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.opcode = ffha_pkg::OP_ALLOC;
    in_bus.request_size = '0;
    in_bus.release_address = '0;
    out_bus.ready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed: zero size, null and unknown free, reuse, double free, merge,
    // heap full with the largest size, then the field extremes.
    pending_reqs.push_back(mk_alloc(0));
    pending_reqs.push_back(mk_free(0));
    pending_reqs.push_back(mk_free(16384));
    pending_reqs.push_back(mk_free(32767));
    pending_reqs.push_back(mk_alloc(1));       // payload 16
    pending_reqs.push_back(mk_alloc(40));      // payload 33
    pending_reqs.push_back(mk_alloc(40));      // payload 89
    pending_reqs.push_back(mk_alloc(5));       // payload 145
    pending_reqs.push_back(mk_free(33));
    pending_reqs.push_back(mk_free(33));       // double free
    pending_reqs.push_back(mk_alloc(39));      // reuse
    pending_reqs.push_back(mk_free(33));
    pending_reqs.push_back(mk_free(89));
    pending_reqs.push_back(mk_alloc(60));      // merge of two
    pending_reqs.push_back(mk_alloc(16384));   // heap full
    pending_reqs.push_back(mk_alloc(32767));
    pending_reqs.push_back(mk_free(16));
    pending_reqs.push_back(mk_alloc(1));       // size equals run, append
    pending_reqs.push_back(mk_free(15));
    // Note: queue is consumed by the driver; predictions happen on accept.
    wait_drained();

    // Table full: fill to MAX_BLOCKS with tiny blocks, then keep asking once it is full.
    for (int i = 0; i < MAX_BLOCKS + 2; i++) pending_reqs.push_back(mk_alloc(2));
    wait_drained();

    // Long receiver hold-off while the sender keeps offering.
    hold_requests++;
    for (int i = 0; i < 30; i++) pending_reqs.push_back(mk_free(pick_addr()));
    wait_drained();
    // Sender pauses until every result is in.
    pause_sender = 1;
    wait_drained();
    pause_sender = 0;

    // Random rounds: a random mix of frees and allocations; reset-free, so the heap
    // top creeps up, after which merges and reuse dominate.
    for (int round = 0; round < 60; round++) begin
      for (int i = 0; i < 18; i++) begin
        if ($urandom_range(99) < 45) begin
          pending_reqs.push_back(mk_free(pick_addr()));
        end else begin
          case ($urandom_range(9))
            0:       sz = $urandom_range(32767);
            1:       sz = 0;
            2, 3:    sz = $urandom_range(400, 1);
            default: sz = $urandom_range(48, 1);
          endcase
          pending_reqs.push_back(mk_alloc(sz));
        end
        // pick_addr uses the shadow table, so let this beat settle first
        wait_drained();
      end
    end
    wait_drained();
    repeat (300) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
